FILE: rtl/qts_pkg.sv
// Shared constants for the quoted token splitter.
package qts_pkg;

    localparam int unsigned MaskWidth  = 64;
    localparam int unsigned MaskRegs   = 4;
    localparam int unsigned CfgIdxW    = 8;
    localparam int unsigned ByteW      = 8;
    localparam int unsigned CountW     = 2;
    localparam int unsigned OutDataW   = 24;

    localparam logic [ByteW-1:0] QUOTE_BYTE = 8'h22;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] REG_DELIM_MASK_0 = 8'd0;
    localparam logic [CfgIdxW-1:0] REG_DELIM_MASK_1 = 8'd1;
    localparam logic [CfgIdxW-1:0] REG_DELIM_MASK_2 = 8'd2;
    localparam logic [CfgIdxW-1:0] REG_DELIM_MASK_3 = 8'd3;

    // Reset mask: TAB, LF, CR and space.
    localparam logic [MaskWidth-1:0] DELIM_MASK_0_RST = 64'h0000_0001_0000_2600;

    localparam logic [CountW-1:0] CNT_NONE = 2'd0;
    localparam logic [CountW-1:0] CNT_ONE  = 2'd1;
    localparam logic [CountW-1:0] CNT_TWO  = 2'd2;

endpackage

FILE: rtl/quoted_token_splitter.sv
// Quoted token splitter: byte stream in, token characters with token end marks out.
//
// Splits each string (one byte per word, tlast on its final byte) into tokens
// separated by runs of delimiter bytes, where the delimiter set is a 256-bit
// mask written through the configuration port (register i covers byte values
// 64*i to 64*i+63). A token that opens with a double quote drops it and ends
// at a quote followed by a delimiter or the string end. The block takes one
// byte per cycle at full rate; each byte passes an input register, one
// classification and state step (a 256-to-1 mask lookup plus a small mode
// update), and a result register on its way to the output. A byte that
// yields a word waits in the input register, holding off the next byte,
// only while the previous word is stalled on the output. Bytes that yield
// no characters and end no token give no output word. Mask writes are
// expected only while the block is idle.
module quoted_token_splitter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [qts_pkg::ByteW-1:0]       s_axis_tdata,   // [7:0] text_byte
    input  logic                            s_axis_tlast,   // string_last
    // Output stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [7:0] first_char, [15:8] second_char, [17:16] char_count, [23:18] zero
    output logic [qts_pkg::OutDataW-1:0]    m_axis_tdata,
    output logic                            m_axis_tlast,   // token_end
    // Configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [qts_pkg::CfgIdxW-1:0]     i_cfg_index,
    input  logic [qts_pkg::MaskWidth-1:0]   i_cfg_data
);

    typedef enum logic [2:0] {
        M_START  = 3'd0,
        M_PLAIN  = 3'd1,
        M_QUOTED = 3'd2,
        M_QHELD  = 3'd3,
        M_GAP    = 3'd4,
        M_PASS   = 3'd5
    } t_mode;

    localparam int unsigned MaskBits = qts_pkg::MaskWidth * qts_pkg::MaskRegs;

    // Delimiter mask and its all-zero flag.
    logic [MaskBits-1:0] r_mask, n_mask;
    logic                r_mask_zero;

    // Input register.
    logic                     r_in_valid;
    logic [qts_pkg::ByteW-1:0] r_in_byte;
    logic                     r_in_last;

    // Scan state and result register.
    t_mode                     r_mode, n_mode;
    logic                      r_out_valid;
    logic [qts_pkg::ByteW-1:0] r_out_first, r_out_second;
    logic [qts_pkg::CountW-1:0] r_out_count;
    logic                      r_out_end;

    logic                      s_accept;
    logic                      out_free;
    logic                      step_go;
    logic                      has_result;
    logic                      is_delim, is_quote;
    logic [qts_pkg::ByteW-1:0] n_first, n_second;
    logic [qts_pkg::CountW-1:0] n_count;
    logic                      n_end;
    t_mode                     step_next;

    assign o_cfg_ready   = 1'b1;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign has_result    = (n_count != qts_pkg::CNT_NONE) || n_end;
    assign step_go       = r_in_valid && (out_free || !has_result);
    assign s_axis_tready = !r_in_valid || step_go;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(qts_pkg::OutDataW - 2*qts_pkg::ByteW - qts_pkg::CountW){1'b0}},
                            r_out_count, r_out_second, r_out_first};
    assign m_axis_tlast  = r_out_end;

    always_comb begin
        n_mask = r_mask;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                qts_pkg::REG_DELIM_MASK_0:
                    n_mask[0*qts_pkg::MaskWidth +: qts_pkg::MaskWidth] = i_cfg_data;
                qts_pkg::REG_DELIM_MASK_1:
                    n_mask[1*qts_pkg::MaskWidth +: qts_pkg::MaskWidth] = i_cfg_data;
                qts_pkg::REG_DELIM_MASK_2:
                    n_mask[2*qts_pkg::MaskWidth +: qts_pkg::MaskWidth] = i_cfg_data;
                qts_pkg::REG_DELIM_MASK_3:
                    n_mask[3*qts_pkg::MaskWidth +: qts_pkg::MaskWidth] = i_cfg_data;
                default: n_mask = r_mask;
            endcase
        end
    end

    assign is_delim = r_mask[r_in_byte];
    assign is_quote = (r_in_byte == qts_pkg::QUOTE_BYTE);

    // One scan step on the registered byte.
    always_comb begin
        n_first   = '0;
        n_second  = '0;
        n_count   = qts_pkg::CNT_NONE;
        n_end     = 1'b0;
        step_next = M_START;
        unique case (r_mode)
            M_PLAIN: begin
                if (is_delim) begin
                    n_end     = 1'b1;
                    step_next = M_GAP;
                end else begin
                    n_first   = r_in_byte;
                    n_count   = qts_pkg::CNT_ONE;
                    n_end     = r_in_last;
                    step_next = M_PLAIN;
                end
            end
            M_QUOTED: begin
                if (is_quote) begin
                    n_end     = r_in_last;
                    step_next = M_QHELD;
                end else begin
                    n_first   = r_in_byte;
                    n_count   = qts_pkg::CNT_ONE;
                    n_end     = r_in_last;
                    step_next = M_QUOTED;
                end
            end
            M_QHELD: begin
                // The held quote closes the token only before a delimiter.
                if (is_delim) begin
                    n_end     = 1'b1;
                    step_next = M_GAP;
                end else if (is_quote) begin
                    n_first   = qts_pkg::QUOTE_BYTE;
                    n_count   = qts_pkg::CNT_ONE;
                    n_end     = r_in_last;
                    step_next = M_QHELD;
                end else begin
                    n_first   = qts_pkg::QUOTE_BYTE;
                    n_second  = r_in_byte;
                    n_count   = qts_pkg::CNT_TWO;
                    n_end     = r_in_last;
                    step_next = M_QUOTED;
                end
            end
            M_PASS: begin
                n_first   = r_in_byte;
                n_count   = qts_pkg::CNT_ONE;
                n_end     = r_in_last;
                step_next = M_PASS;
            end
            default: begin
                // Start of string or gap between tokens.
                if (r_mode == M_START && r_mask_zero) begin
                    n_first   = r_in_byte;
                    n_count   = qts_pkg::CNT_ONE;
                    n_end     = r_in_last;
                    step_next = M_PASS;
                end else if (is_delim) begin
                    n_end     = r_in_last && (r_mode == M_START);
                    step_next = (r_mode == M_GAP) ? M_GAP : M_START;
                end else if (is_quote) begin
                    n_end     = r_in_last;
                    step_next = M_QUOTED;
                end else begin
                    n_first   = r_in_byte;
                    n_count   = qts_pkg::CNT_ONE;
                    n_end     = r_in_last;
                    step_next = M_PLAIN;
                end
            end
        endcase
        n_mode = r_in_last ? M_START : step_next;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= {{(MaskBits - qts_pkg::MaskWidth){1'b0}}, qts_pkg::DELIM_MASK_0_RST};
            r_mask_zero <= 1'b0;
            r_in_valid  <= 1'b0;
            r_mode      <= M_START;
            r_out_valid <= 1'b0;
        end else begin
            r_mask      <= n_mask;
            r_mask_zero <= ~|n_mask;
            if (s_accept) begin
                r_in_valid <= 1'b1;
            end else if (step_go) begin
                r_in_valid <= 1'b0;
            end
            if (step_go) begin
                r_mode <= n_mode;
            end
            if (step_go && has_result) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
        if (step_go && has_result) begin
            r_out_first  <= n_first;
            r_out_second <= n_second;
            r_out_count  <= n_count;
            r_out_end    <= n_end;
        end
    end

    // A word with no characters must be a token end.
    a_empty_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_count == qts_pkg::CNT_NONE |-> r_out_end)
        else $error("empty output word without token end");

    // The second character is only carried in a two-character word.
    a_second_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_count != qts_pkg::CNT_TWO |-> r_out_second == '0)
        else $error("second_char set outside a two-character word");

    // The character count never exceeds two.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_count != 2'd3)
        else $error("char_count out of range");

    // The last byte of a string returns the scanner to the start state.
    a_last_resets_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_go && r_in_last |=> r_mode == M_START)
        else $error("scan mode not restarted after string end");

    // A stalled result word is not overwritten.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |=> r_out_valid && $stable(m_axis_tdata))
        else $error("stalled result word changed");

endmodule
